// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/msps_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper phase scheduler package
// Sizes, request and result types, and the full-step phase order.
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int MOTORS        = 8;
    localparam int POSITION_BITS = 16;
    localparam int MOTOR_IDX_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int MOTOR_CNT_W   = $clog2(MOTORS + 1);
    localparam int NIBBLE_W      = 4;
    localparam int FRAME_SLOTS   = (MOTORS < 8) ? MOTORS : 8;
    localparam int USED_W        = 4;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] PH0 = 2'b00;
    localparam logic [1:0] PH1 = 2'b01;
    localparam logic [1:0] PH2 = 2'b10;
    localparam logic [1:0] PH3 = 2'b11;

    typedef struct packed {
        logic               kind;
        logic [2:0]         motor;
        logic signed [15:0] target;
        logic               counterclockwise;
    } cmd_t;

    typedef struct packed {
        logic [31:0] frame;
        logic        all_idle;
    } res_t;

    function automatic logic [1:0] next_phase(input logic [1:0] ph, input logic ccw);
        logic [1:0] n;
        n = PH0;
        if (ccw)
        begin
            case (ph)
                PH0:     n = PH1;
                PH1:     n = PH3;
                PH3:     n = PH2;
                default: n = PH0;
            endcase
        end
        else
        begin
            case (ph)
                PH0:     n = PH2;
                PH2:     n = PH3;
                PH3:     n = PH1;
                default: n = PH0;
            endcase
        end
        return n;
    endfunction

endpackage

// ----- hdl/msps_ram.sv -----
// ----------------------------------------------------------------------------
// Motor record RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/multi_stepper_phase_scheduler.sv -----
// ----------------------------------------------------------------------------
// Multi stepper phase scheduler: a set target is written on acceptance; a tick
// with no busy motor goes straight to the output state, otherwise the RAM scan
// visits one motor per cycle through the motors in service before output.
// Async reset clears flags, valid bits and frame; motors_used resets to 8.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_stepper_phase_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  msps_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output msps_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data
);

    import msps_pkg::*;

    localparam int TW = POSITION_BITS + 1;
    localparam int PW = POSITION_BITS + 2;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

    state_t                   state_reg;
    logic [MOTOR_IDX_W-1:0]   cur_reg;
    logic [MOTOR_CNT_W-1:0]   used_reg;
    logic                     idle_reg;
    logic [MOTORS-1:0]        active_reg;
    logic [MOTORS-1:0]        enable_reg;
    logic [MOTORS-1:0]        tvld_reg;
    logic [MOTORS-1:0]        pvld_reg;
    logic                     tq_vld_reg;
    logic                     pq_vld_reg;
    logic [NIBBLE_W-1:0]      frame_reg [MOTORS];
    logic [USED_W-1:0]        motors_used_reg;
    logic                     res_valid_reg;
    res_t                     res_reg;

    logic                     accept;
    logic                     t_wr_en;
    logic [MOTOR_IDX_W-1:0]   t_wr_addr;
    logic [TW-1:0]            t_wr_data;
    logic [TW-1:0]            t_rd_data;
    logic                     p_wr_en;
    logic [PW-1:0]            p_wr_data;
    logic [PW-1:0]            p_rd_data;
    logic [MOTOR_IDX_W-1:0]   rd_addr;
    logic [MOTOR_CNT_W-1:0]   used_eff;
    logic                     busy;
    logic [POSITION_BITS-1:0] tgt;
    logic                     dir;
    logic [1:0]               ph;
    logic [POSITION_BITS-1:0] pos;
    logic [1:0]               ph_next;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     stepping;
    logic                     last;
    logic [31:0]              frame_word;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign accept    = cmd_valid && cmd_ready;

    assign t_wr_en   = accept && (cmd.kind == KIND_SET) && (int'(cmd.motor) < MOTORS);
    assign t_wr_addr = MOTOR_IDX_W'(cmd.motor);
    assign t_wr_data = {cmd.counterclockwise, POSITION_BITS'(cmd.target)};
    assign rd_addr   = (state_reg == S_SCAN) ? cur_reg + MOTOR_IDX_W'(1) : '0;

    msps_ram #(.WIDTH(TW), .DEPTH(MOTORS)) u_target_ram (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data),
        .rd_addr (rd_addr),
        .rd_data (t_rd_data)
    );

    msps_ram #(.WIDTH(PW), .DEPTH(MOTORS)) u_motion_ram (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (cur_reg),
        .wr_data (p_wr_data),
        .rd_addr (rd_addr),
        .rd_data (p_rd_data)
    );

    always_comb
    begin
        used_eff = (int'(motors_used_reg) > MOTORS) ? MOTOR_CNT_W'(MOTORS)
                                                    : MOTOR_CNT_W'(motors_used_reg);
        busy = 1'b0;
        for (int m = 0; m < MOTORS; m++)
        begin
            if (active_reg[m] && (MOTOR_CNT_W'(m) < used_eff))
            begin
                busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        tgt = tq_vld_reg ? t_rd_data[POSITION_BITS-1:0] : '0;
        dir = tq_vld_reg ? t_rd_data[POSITION_BITS] : 1'b0;
        ph  = pq_vld_reg ? p_rd_data[1:0] : PH0;
        pos = pq_vld_reg ? p_rd_data[PW-1:2] : '0;
        ph_next  = next_phase(ph, dir);
        pos_next = pos;
        if (!dir && (ph == PH2))
        begin
            pos_next = pos + POSITION_BITS'(1);
        end
        else if (dir && (ph == PH1))
        begin
            pos_next = pos - POSITION_BITS'(1);
        end
        stepping  = active_reg[cur_reg] && (tgt != pos);
        p_wr_en   = (state_reg == S_SCAN) && stepping;
        p_wr_data = {pos_next, ph_next};
        last      = (MOTOR_CNT_W'(cur_reg) + MOTOR_CNT_W'(1)) == used_reg;
    end

    always_comb
    begin
        frame_word = '0;
        for (int s = 0; s < FRAME_SLOTS; s++)
        begin
            frame_word[NIBBLE_W*s +: NIBBLE_W] = frame_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_reg         <= '0;
            used_reg        <= '0;
            idle_reg        <= 1'b0;
            active_reg      <= '0;
            enable_reg      <= '0;
            tvld_reg        <= '0;
            pvld_reg        <= '0;
            tq_vld_reg      <= 1'b0;
            pq_vld_reg      <= 1'b0;
            motors_used_reg <= USED_W'(8);
            res_valid_reg   <= 1'b0;
            for (int m = 0; m < MOTORS; m++)
            begin
                frame_reg[m] <= '0;
            end
        end
        else
        begin
            tq_vld_reg <= tvld_reg[rd_addr];
            pq_vld_reg <= pvld_reg[rd_addr];
            if (cfg_valid)
            begin
                motors_used_reg <= cfg_data;
            end
            if (res_valid_reg && res_ready && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end
            if (t_wr_en)
            begin
                tvld_reg[t_wr_addr]   <= 1'b1;
                active_reg[t_wr_addr] <= 1'b1;
                enable_reg[t_wr_addr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd.kind == KIND_TICK))
                    begin
                        used_reg <= used_eff;
                        cur_reg  <= '0;
                        idle_reg <= !busy;
                        state_reg <= busy ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN:
                begin
                    if (active_reg[cur_reg])
                    begin
                        if (stepping)
                        begin
                            pvld_reg[cur_reg]  <= 1'b1;
                            frame_reg[cur_reg] <= {1'b0, enable_reg[cur_reg], ph_next};
                        end
                        else
                        begin
                            active_reg[cur_reg] <= 1'b0;
                            enable_reg[cur_reg] <= 1'b0;
                            frame_reg[cur_reg]  <= {2'b00, ph};
                        end
                    end
                    if (last)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + MOTOR_IDX_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!res_valid_reg || res_ready))
        begin
            res_reg.frame    <= idle_reg ? 32'd0 : frame_word;
            res_reg.all_idle <= idle_reg;
        end
    end

    `ASSERT_IMPLIES(a_scan_in_range, (state_reg == S_SCAN),
                    (MOTOR_CNT_W'(cur_reg) < used_reg), "scan index past motors in service")
    `ASSERT_IMPLIES(a_idle_frame_zero, (res_valid_reg && res_reg.all_idle),
                    (res_reg.frame == 32'd0), "all-idle result with nonzero frame")
    `ASSERT_NEXT(a_idle_tick, (accept && (cmd.kind == KIND_TICK) && !busy),
                 ((state_reg == S_OUT) && idle_reg), "idle tick did not go to output")

endmodule
